// ----- src/extended_gcd_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// Extended GCD engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_GCD_ENGINE_CORE_MACROS_SVH
`define EXTENDED_GCD_ENGINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Extended GCD engine package
// Field widths and the status bundle shared by the engine and its divider.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int FIELD_BITS = 63;
  localparam int COEFF_BITS = 64;

  typedef logic [COEFF_BITS-1:0] coeff_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/egcd_div.sv -----
// ----------------------------------------------------------------------------
// Extended GCD serial divider
// Restoring radix-2 divider producing one quotient bit per cycle. Each
// quotient bit is folded MSB first into two 64-bit products q*s and q*t.
// ----------------------------------------------------------------------------
module egcd_div
  import egcd_pkg::*;
#(
  parameter int VALUE_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  input  coeff_t                mult_s_in,
  input  coeff_t                mult_t_in,
  output div_stat_t             stat,
  output logic [VALUE_BITS-1:0] remainder,
  output coeff_t                prod_s,
  output coeff_t                prod_t
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] dvd;
  logic [VALUE_BITS-1:0] dvs;
  logic [VALUE_BITS-1:0] rem;
  coeff_t                mult_s;
  coeff_t                mult_t;
  coeff_t                acc_s;
  coeff_t                acc_t;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  qbit;
  logic [VALUE_BITS-1:0] rem_next;

  // The partial remainder always stays below the divisor, so it fits in
  // VALUE_BITS bits after each step.
  always_comb begin
    trial    = {rem, dvd[VALUE_BITS-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = ~diff[VALUE_BITS];
    rem_next = qbit ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd    <= dividend;
      dvs    <= divisor;
      rem    <= '0;
      mult_s <= mult_s_in;
      mult_t <= mult_t_in;
      acc_s  <= '0;
      acc_t  <= '0;
    end else if (busy) begin
      dvd   <= dvd << 1;
      rem   <= rem_next;
      acc_s <= (acc_s << 1) + (qbit ? mult_s : '0);
      acc_t <= (acc_t << 1) + (qbit ? mult_t : '0);
    end
  end

  assign stat      = '{busy: busy, done: done};
  assign remainder = rem;
  assign prod_s    = acc_s;
  assign prod_t    = acc_t;

endmodule

// ----- src/extended_gcd_engine_core.sv -----
// ----------------------------------------------------------------------------
// Extended GCD engine
// Extended Euclidean algorithm: gcd, Bezout coefficients and inverse mod b.
// ----------------------------------------------------------------------------
// Usage: an item (value_a, value_b) enters on in_valid/in_ready; one result
// item (gcd_out, coeff_a, coeff_b, inverse_mod_b) leaves on
// out_valid/out_ready. Only the low VALUE_BITS bits of each operand are used.
// The engine works on one item at a time. Each Euclid step is one pass of the
// serial divider, which yields one quotient bit per cycle while it accumulates
// q*s and q*t. For 63-bit operands an item has at most about 92 steps.
// The result sits in an output register: a new item is taken while it waits,
// and a finished item holds in the engine until the output register frees up
// when the receiver stalls. Synchronous reset drops any item in flight and
// clears out_valid.
// ----------------------------------------------------------------------------
`include "extended_gcd_engine_core_macros.svh"

module extended_gcd_engine_core
  import egcd_pkg::*;
#(
  parameter int VALUE_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_BITS-1:0] value_a,
  input  logic [FIELD_BITS-1:0] value_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_BITS-1:0] gcd_out,
  output coeff_t                coeff_a,
  output coeff_t                coeff_b,
  output logic [FIELD_BITS-1:0] inverse_mod_b
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] r_prev;
  logic [VALUE_BITS-1:0] r_cur;
  logic [VALUE_BITS-1:0] b_keep;
  coeff_t                s_prev;
  coeff_t                s_cur;
  coeff_t                t_prev;
  coeff_t                t_cur;

  logic                  div_start;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_rem;
  coeff_t                prod_s;
  coeff_t                prod_t;

  logic                  load_out;
  coeff_t                inv_full;

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_CHECK) && (r_cur != '0);
  assign load_out  = (state == S_FINISH) && (!out_valid || out_ready);

  // A negative coefficient is brought into range by adding the modulus.
  assign inv_full = s_prev[COEFF_BITS-1] ? (s_prev + COEFF_BITS'(b_keep)) : s_prev;

  egcd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (r_prev),
    .divisor   (r_cur),
    .mult_s_in (s_cur),
    .mult_t_in (t_cur),
    .stat      (div_stat),
    .remainder (div_rem),
    .prod_s    (prod_s),
    .prod_t    (prod_t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (r_cur == '0) ? S_FINISH : S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r_prev <= value_a[VALUE_BITS-1:0];
      r_cur  <= value_b[VALUE_BITS-1:0];
      b_keep <= value_b[VALUE_BITS-1:0];
      s_prev <= COEFF_BITS'(1);
      s_cur  <= '0;
      t_prev <= '0;
      t_cur  <= COEFF_BITS'(1);
    end else if ((state == S_DIV) && div_stat.done) begin
      r_prev <= r_cur;
      r_cur  <= div_rem;
      s_prev <= s_cur;
      s_cur  <= s_prev - prod_s;
      t_prev <= t_cur;
      t_cur  <= t_prev - prod_t;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gcd_out       <= FIELD_BITS'(r_prev);
      coeff_a       <= s_prev;
      coeff_b       <= t_prev;
      inverse_mod_b <= inv_full[FIELD_BITS-1:0];
    end
  end

  `EGCD_ASSERT_SAME(a_idle_div_quiet, in_ready, !div_stat.busy,
    "divider busy while the engine takes an item")
  `EGCD_ASSERT_SAME(a_done_in_div, div_stat.done, state == S_DIV,
    "divider finished outside a division step")
  `EGCD_ASSERT_SAME(a_finish_zero, state == S_FINISH, r_cur == '0,
    "result produced before the divisor reached zero")
  `EGCD_ASSERT_NEXT(a_rem_shrinks, (state == S_DIV) && div_stat.done,
    r_cur < $past(r_cur), "remainder did not shrink across a step")

endmodule
